### rtl/afl_pkg.sv
// shared types, constants and the sine table function for the flanger
// no dependencies; imported by every module of the block
package afl_pkg;

	// default sizes handed to the top-level parameters
	localparam int DELAY_DEPTH_DEF     = 256;
	localparam int SINE_TABLE_SIZE_DEF = 256;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_EFFECT_ENABLE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BASE_DELAY    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_SWING         = 3'd2;
	localparam logic [CFG_AW-1:0] REG_DEPTH_GAIN    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_OUT_SCALE     = 3'd4;
	localparam logic [CFG_AW-1:0] REG_LFO_STEP      = 3'd5;

	// register reset values
	localparam logic        EFFECT_ENABLE_RST = 1'b1;
	localparam logic [6:0]  BASE_DELAY_RST    = 7'd100;
	localparam logic [15:0] SWING_RST         = 16'd16384;
	localparam logic [15:0] DEPTH_GAIN_RST    = 16'd32768;
	localparam logic [15:0] OUT_SCALE_RST     = 16'd16384;
	localparam logic [15:0] LFO_STEP_RST      = 16'd8;

	// input and result words
	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
	} out_word_t;

	// delay line controls from the sequencer
	typedef struct packed {
		logic wr;   // write the mono word at the write pointer
		logic rd;   // read the tap selected by back
		logic adv;  // step the write pointer
	} dl_ctrl_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINE,
		ST_FACT,
		ST_RD0,
		ST_RD1,
		ST_MIX,
		ST_ACC,
		ST_OUT
	} afl_state_t;

	// polynomial sine of a Q16 turn fraction, Q1.15 result
	function automatic logic signed [15:0] sine_of_phase(input logic [15:0] p);
		logic [1:0]  quad;
		int unsigned r;
		int unsigned u;
		int unsigned u2;
		int unsigned t;
		int unsigned s;
		quad = p[15:14];
		r    = {18'd0, p[13:0]};
		u    = quad[0] ? 32'd16384 - r : r;
		u2   = (u * u) >> 14;
		t    = (32'd2611 * u2) >> 14;
		t    = ((32'd21167 - t) * u2) >> 14;
		s    = ((32'd51472 - t) * u) >> 14;
		if (s > 32'd32767) s = 32'd32767;
		return quad[1] ? -$signed(16'(s)) : $signed(16'(s));
	endfunction

endpackage

### rtl/afl_sine_rom.sv
// constant sine table for the lfo, registered read
// depends on afl_pkg for sine_of_phase
module afl_sine_rom import afl_pkg::*; #(
	parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF,
	localparam int SW = $clog2(SINE_TABLE_SIZE)
) (
	input  logic                 clk,
	input  logic [SW-1:0]        idx,
	output logic signed [15:0]   sine
);

	logic signed [15:0] rom [SINE_TABLE_SIZE];

	// table entries worked out at elaboration
	for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
		localparam int P = (g * 65536) / SINE_TABLE_SIZE;
		assign rom[g] = sine_of_phase(16'(P));
	end

	// registered lookup
	always_ff @(posedge clk) begin
		sine <= rom[idx];
	end

endmodule

### rtl/afl_delay_line.sv
// circular delay line: one synchronous memory, write pointer and fill count
// depends on afl_pkg for dl_ctrl_t
module afl_delay_line import afl_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	localparam int AW = $clog2(DELAY_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dl_ctrl_t             ctrl,
	input  logic signed [15:0]   wr_data,
	input  logic [AW-1:0]        back,
	output logic signed [15:0]   rd_data
);

	localparam int FW = $clog2(DELAY_DEPTH + 1);

	logic signed [15:0] mem_q [DELAY_DEPTH];
	logic [AW-1:0]      wp_q;
	logic [FW-1:0]      fill_q;
	logic signed [15:0] rd_q;
	logic               vld_q;
	logic [AW:0]        diff;
	logic [AW:0]        wrap;
	logic [AW-1:0]      rd_idx;
	logic               rd_vld;

	// tap address: back samples behind the write pointer, modulo depth
	assign diff   = {1'b0, wp_q} - {1'b0, back};
	assign wrap   = {1'b0, wp_q} + (AW + 1)'(DELAY_DEPTH) - {1'b0, back};
	assign rd_idx = (wp_q >= back) ? diff[AW-1:0] : wrap[AW-1:0];

	// entries are written in pointer order, so the fill count marks the written ones
	assign rd_vld = FW'(rd_idx) < fill_q;

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (ctrl.wr && fill_q != FW'(DELAY_DEPTH)) fill_q <= fill_q + FW'(1);
			if (ctrl.adv) wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (ctrl.rd) vld_q <= rd_vld;
		end
	end

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctrl.wr) mem_q[wp_q] <= wr_data;
		if (ctrl.rd) rd_q <= mem_q[rd_idx];
	end

	// never-written entries read as zero
	assign rd_data = vld_q ? rd_q : '0;

endmodule

### rtl/audio_flanger_unit.sv
// Stereo flanger with a sine-modulated fractional delay line.
//
// Input channel (sample_valid/sample_ready/sample) takes one stereo word;
// result channel (result_valid/result_ready/result) gives one stereo word
// per input word, in order. Configuration is a plain write port
// (cfg_wen/cfg_addr/cfg_wdata); user writes it only when idle, unchecked.
//
// With the effect on, a word goes from acceptance to the result register
// through sine lookup, delay factor, two reads of the delay-line memory,
// interpolation, mix and output scaling, sequenced one step a cycle; the
// last step holds while the result register is full and not taken.
// In bypass a word goes from idle straight to the output step. One word
// is in work at a time; sample_ready is high while the sequencer is idle.
//
// A finished word waits in the result register; the next input word is
// still accepted, and its finished result waits in the last step until
// the receiver takes the previous one.
// Reset clears the registers to their defaults, the write pointer, the
// lfo phase and the fill count; the delay line reads as silence until
// written, so no clearing pass is needed.
module audio_flanger_unit import afl_pkg::*; #(
	parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
	parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  in_word_t             sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_word_t            result,
	input  logic                 cfg_wen,
	input  logic [CFG_AW-1:0]    cfg_addr,
	input  logic [CFG_DW-1:0]    cfg_wdata
);

	localparam int AW   = $clog2(DELAY_DEPTH);
	localparam int SW   = $clog2(SINE_TABLE_SIZE);
	localparam int DW   = AW + 8;
	localparam int DMAX = (DELAY_DEPTH - 2) * 256 + 255;

	// configuration registers
	logic        enable_q;
	logic [6:0]  base_q;
	logic [15:0] swing_q;
	logic [15:0] depth_q;
	logic [15:0] scale_q;
	logic [15:0] step_q;

	// control state
	afl_state_t  state_q, state_d;
	logic [15:0] phase_q;
	logic        out_valid_q;
	out_word_t   out_q;
	dl_ctrl_t    dl_ctrl;
	logic        accept;
	logic        load;

	// payload registers
	logic signed [15:0] l_q, r_q, x_q;
	logic               byp_q;
	logic signed [32:0] prod_s1;
	logic [DW-1:0]      d_s1;
	logic signed [25:0] p0_s1;
	logic signed [15:0] y_s1;
	logic signed [33:0] acc_s1;

	// datapath nets
	logic [31:0]        sidx_full;
	logic [SW-1:0]      sidx;
	logic signed [15:0] sine;
	logic signed [15:0] x_new;
	logic signed [32:0] swing_ext, sine_ext, prod;
	logic signed [32:0] fsum;
	logic [16:0]        f;
	logic [23:0]        dprod;
	logic [16:0]        dsh;
	logic [DW-1:0]      d_new;
	logic [AW-1:0]      k;
	logic [7:0]         frac;
	logic [AW-1:0]      back;
	logic signed [15:0] tap;
	logic [8:0]         w0;
	logic signed [25:0] p0, mix;
	logic signed [15:0] y_new;
	logic signed [33:0] acc_new;
	logic signed [51:0] oprod, osh;
	logic signed [15:0] osat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= EFFECT_ENABLE_RST;
			base_q   <= BASE_DELAY_RST;
			swing_q  <= SWING_RST;
			depth_q  <= DEPTH_GAIN_RST;
			scale_q  <= OUT_SCALE_RST;
			step_q   <= LFO_STEP_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_EFFECT_ENABLE: enable_q <= cfg_wdata[0];
				REG_BASE_DELAY:    base_q   <= cfg_wdata[6:0];
				REG_SWING:         swing_q  <= cfg_wdata;
				REG_DEPTH_GAIN:    depth_q  <= cfg_wdata;
				REG_OUT_SCALE:     scale_q  <= cfg_wdata;
				REG_LFO_STEP:      step_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign load         = (state_q == ST_OUT) && (!out_valid_q || result_ready);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and delay line controls
	always_comb begin
		state_d     = state_q;
		dl_ctrl.wr  = 1'b0;
		dl_ctrl.rd  = 1'b0;
		dl_ctrl.adv = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = enable_q ? ST_SINE : ST_OUT;
			ST_SINE: begin
				dl_ctrl.wr = 1'b1;
				state_d    = ST_FACT;
			end
			ST_FACT: state_d = ST_RD0;
			ST_RD0: begin
				dl_ctrl.rd = 1'b1;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				dl_ctrl.rd = 1'b1;
				state_d    = ST_MIX;
			end
			ST_MIX: state_d = ST_ACC;
			ST_ACC: state_d = ST_OUT;
			ST_OUT: if (load) begin
				dl_ctrl.adv = !byp_q;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// lfo table index from the phase accumulator
	assign sidx_full = (32'(phase_q) * 32'(SINE_TABLE_SIZE)) >> 16;
	assign sidx      = sidx_full[SW-1:0];

	afl_sine_rom #(
		.SINE_TABLE_SIZE(SINE_TABLE_SIZE)
	) u_sine (
		.clk  (clk),
		.idx  (sidx),
		.sine (sine)
	);

	// mono mix
	assign x_new = (sample.left_sample >>> 1) + (sample.right_sample >>> 1);

	// swing times sine
	assign swing_ext = {17'd0, swing_q};
	assign sine_ext  = 33'(sine);
	assign prod      = swing_ext * sine_ext;

	// delay factor, clamped at zero, then q8.8 delay clamped to the line
	assign fsum  = (prod_s1 >>> 15) + 33'sd32768;
	assign f     = fsum[32] ? '0 : fsum[16:0];
	assign dprod = {17'd0, base_q} * {7'd0, f};
	assign dsh   = dprod[23:7];
	assign d_new = (32'(dsh) > 32'(DMAX)) ? DW'(DMAX) : DW'(dsh);

	// tap selection: integer part, then one further back
	assign k    = d_s1[DW-1:8];
	assign frac = d_s1[7:0];
	assign back = (state_q == ST_RD1) ? k + AW'(1) : k;

	afl_delay_line #(
		.DELAY_DEPTH(DELAY_DEPTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (dl_ctrl),
		.wr_data (x_q),
		.back    (back),
		.rd_data (tap)
	);

	// linear interpolation: first tap weighted in the second read state, second tap in the mix state
	assign w0    = 9'd256 - {1'b0, frac};
	assign p0    = 26'(tap) * $signed({17'd0, w0});
	assign mix   = p0_s1 + 26'(tap) * $signed({18'd0, frac});
	assign y_new = 16'(mix >>> 8);

	// dry plus scaled wet
	assign acc_new = (34'(x_q) <<< 15) + $signed({18'd0, depth_q}) * 34'(y_s1);

	// output scaling and saturation
	assign oprod = 52'(acc_s1) * $signed({36'd0, scale_q});
	assign osh   = oprod >>> 30;
	always_comb begin
		if (osh > 52'sd32767)       osat = 16'sh7fff;
		else if (osh < -52'sd32768) osat = -16'sd32768;
		else                        osat = osh[15:0];
	end

	// datapath registers, one step per state
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				l_q   <= sample.left_sample;
				r_q   <= sample.right_sample;
				x_q   <= x_new;
				byp_q <= !enable_q;
			end
			ST_SINE: prod_s1 <= prod;
			ST_FACT: d_s1    <= d_new;
			ST_RD1:  p0_s1   <= p0;
			ST_MIX:  y_s1    <= y_new;
			ST_ACC:  acc_s1  <= acc_new;
			default: ;
		endcase
	end

	// lfo phase advances once per flanged word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)              phase_q <= '0;
		else if (load && !byp_q)  phase_q <= phase_q + step_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_valid_q <= 1'b0;
		else if (load)          out_valid_q <= 1'b1;
		else if (result_ready)  out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_left  <= byp_q ? l_q : osat;
			out_q.out_right <= byp_q ? r_q : osat;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/afl_checker.sv
// port-level checks for the flanger top level, attached by bind
// depends on afl_pkg for out_word_t
module afl_checker import afl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      sample_valid,
	input logic      sample_ready,
	input logic      result_valid,
	input logic      result_ready,
	input out_word_t result
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = result_valid && result_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else         pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one word in work at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !sample_ready)
		else $error("input taken while a word is in work");

	// no result without an accepted word
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result with nothing pending");

	// at most one finished word waits while ready
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> pend_q != 2'd2)
		else $error("ready with two words pending");

endmodule

bind audio_flanger_unit afl_checker u_afl_checker (.*);

### dv/afl_flange_checker.sv
`timescale 1ns / 1ps
// checker for the flanger: mirrors the register writes, predicts each result word
// from every accepted input word and compares it with what the block hands out
// depends on afl_pkg for the word types and register indexes
module afl_flange_checker import afl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_ready,
	input  in_word_t          sample,
	input  logic              result_valid,
	input  logic              result_ready,
	input  out_word_t         result,
	input  logic              cfg_wen,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output int                n_pending,
	output int                n_errors
);

	localparam int     LINE_LEN = DELAY_DEPTH_DEF;
	localparam int     SINE_LEN = SINE_TABLE_SIZE_DEF;
	localparam longint DLY_MAX  = longint'(LINE_LEN - 2) * 256 + 255;

	// register mirror
	logic        fx_on;
	logic [6:0]  base_q;
	logic [15:0] swing_q;
	logic [15:0] depth_q;
	logic [15:0] scale_q;
	logic [15:0] step_q;

	// delay line, write position and lfo phase as the block should hold them
	logic signed [15:0] echo_mem [LINE_LEN];
	int                 wr_idx;
	logic [15:0]        lfo_ph;

	out_word_t due_words [$];
	out_word_t want;
	int        errs;

	// polynomial sine of the table entry picked by the phase, q1.15
	function automatic longint lfo_sine(input logic [15:0] ph);
		longint idx, p, r, u, u2, t, s;
		idx = (longint'(ph) * SINE_LEN) >> 16;
		p   = ((idx * 65536) / SINE_LEN) & 16'hFFFF;
		r   = p & 16'h3FFF;
		u   = p[14] ? 16384 - r : r;
		u2  = (u * u) >> 14;
		t   = (2611 * u2) >> 14;
		t   = ((21167 - t) * u2) >> 14;
		s   = ((51472 - t) * u) >> 14;
		if (s > 32767) s = 32767;
		return p[15] ? -s : s;
	endfunction

	// stored word a given number of samples back from the write position
	function automatic longint line_tap(input longint back);
		int i;
		i = (wr_idx + LINE_LEN - int'(back % LINE_LEN)) % LINE_LEN;
		return longint'(echo_mem[i]);
	endfunction

	// one sample through the flanger, state updated as the block does
	function automatic out_word_t flange_step(input in_word_t w);
		longint    l, r, x, s, f, d, k, frac, y, acc, o;
		out_word_t res;
		if (!fx_on) begin
			res.out_left  = w.left_sample;
			res.out_right = w.right_sample;
			return res;
		end
		l = longint'($signed(w.left_sample));
		r = longint'($signed(w.right_sample));
		x = (l >>> 1) + (r >>> 1);
		echo_mem[wr_idx] = x[15:0];
		// modulated delay in q8.8, negative factor floors at zero
		s = lfo_sine(lfo_ph);
		f = 32768 + ((longint'(swing_q) * s) >>> 15);
		if (f < 0) f = 0;
		d = (longint'(base_q) * f) >>> 7;
		if (d > DLY_MAX) d = DLY_MAX;
		k    = d >> 8;
		frac = d & 255;
		// linear interpolation between the two taps
		y   = (line_tap(k) * (256 - frac) + line_tap(k + 1) * frac) >>> 8;
		acc = x * 32768 + longint'(depth_q) * y;
		o   = (acc * longint'(scale_q)) >>> 30;
		if (o > 32767) o = 32767;
		if (o < -32768) o = -32768;
		res.out_left  = o[15:0];
		res.out_right = o[15:0];
		wr_idx = (wr_idx + 1) % LINE_LEN;
		lfo_ph = lfo_ph + step_q;
		return res;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_on   = EFFECT_ENABLE_RST;
			base_q  = BASE_DELAY_RST;
			swing_q = SWING_RST;
			depth_q = DEPTH_GAIN_RST;
			scale_q = OUT_SCALE_RST;
			step_q  = LFO_STEP_RST;
			for (int i = 0; i < LINE_LEN; i++) echo_mem[i] = '0;
			wr_idx  = 0;
			lfo_ph  = '0;
			due_words.delete();
			errs    = 0;
			n_pending <= 0;
			n_errors  <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_addr)
					REG_EFFECT_ENABLE: fx_on   = cfg_wdata[0];
					REG_BASE_DELAY:    base_q  = cfg_wdata[6:0];
					REG_SWING:         swing_q = cfg_wdata;
					REG_DEPTH_GAIN:    depth_q = cfg_wdata;
					REG_OUT_SCALE:     scale_q = cfg_wdata;
					REG_LFO_STEP:      step_q  = cfg_wdata;
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) due_words.push_back(flange_step(sample));
			// compare the result word with the oldest prediction
			if (result_valid && result_ready) begin
				if (due_words.size() == 0) begin
					$display("%0t: result word with none expected, got %0d %0d",
						$time, result.out_left, result.out_right);
					errs++;
				end else begin
					want = due_words.pop_front();
					if (result.out_left !== want.out_left) begin
						$display("%0t: out_left expected %0d got %0d",
							$time, want.out_left, result.out_left);
						errs++;
					end
					if (result.out_right !== want.out_right) begin
						$display("%0t: out_right expected %0d got %0d",
							$time, want.out_right, result.out_right);
						errs++;
					end
				end
			end
			n_pending <= due_words.size();
			n_errors  <= errs;
		end
	end

endmodule

### dv/tb_audio_flanger_unit.sv
`timescale 1ns / 1ps
// top of the flanger testbench: clock, reset, register programming and word traffic
// with random gaps on both channels; depends on afl_pkg, audio_flanger_unit and afl_flange_checker
module tb_audio_flanger_unit;
	import afl_pkg::*;

	// indexes past the last register, writes there must change nothing
	localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	in_word_t          sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	out_word_t         result;
	logic              cfg_wen = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	int                pending_words;
	int                mismatch_count;
	bit                steady = 1'b0;

	always #5 clk = ~clk;

	audio_flanger_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	afl_flange_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.n_pending    (pending_words),
		.n_errors     (mismatch_count)
	);

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// full-range, quiet or extreme sample values
	function automatic logic signed [15:0] rand_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 16'($urandom);
		if (roll < 80) return 16'($urandom_range(0, 512) - 256);
		case ($urandom_range(0, 4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return -16'sd1;
			3: return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic en, input logic [6:0] base,
			input logic [15:0] sw, input logic [15:0] dg, input logic [15:0] sc,
			input logic [15:0] st);
		write_reg(REG_EFFECT_ENABLE, {15'd0, en});
		write_reg(REG_BASE_DELAY, {9'd0, base});
		write_reg(REG_SWING, sw);
		write_reg(REG_DEPTH_GAIN, dg);
		write_reg(REG_OUT_SCALE, sc);
		write_reg(REG_LFO_STEP, st);
		cfg_wen <= 1'b0;
	endtask

	// offer one word after a random gap, return once it is taken
	task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= in_word_t'({l, r});
		do @(posedge clk); while (!sample_ready);
	endtask

	// stop offering and wait for every predicted word to come back
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
	endtask

	// receiver: gaps after words taken, and one long hold to back the block up
	initial begin
		int hold;
		int taken;
		bit long_done;
		hold      = 0;
		taken     = 0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				taken++;
				hold = pick_gap();
			end
			if (!long_done && taken >= 150) begin
				long_done = 1'b1;
				hold      = 250;
			end
			if (hold > 0) begin
				result_ready <= 1'b0;
				hold--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic        en;
		logic [6:0]  base;
		logic [15:0] sw, dg, sc, st;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, extremes of both fields
		send_word(16'sh7FFF, 16'sh7FFF);
		send_word(16'sh8000, 16'sh8000);
		send_word(16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF);
		send_word(16'sd0, 16'sd0);
		send_word(-16'sd1, -16'sd1);
		send_word(16'sd1, 16'sd1);
		send_word(-16'sd1, 16'sd0);
		drain();

		// bypass passes both channels straight through
		program_regs(1'b0, 7'd100, 16'd16384, 16'd32768, 16'd16384, 16'd8);
		send_word(16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF);
		send_word(-16'sd1, 16'sd1);
		drain();

		// delay past the end of the line and negative delay factor,
		// eighth-turn steps so every sine quadrant shows up; spare indexes ignored
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0000);
		program_regs(1'b1, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h2000);
		for (int i = 0; i < 8; i++) begin
			if (i[0]) send_word(16'sh8000, 16'sh8000);
			else send_word(16'sh7FFF, 16'sh7FFF);
		end
		drain();

		// zero base delay
		program_regs(1'b1, 7'd0, 16'd32768, 16'd32768, 16'd32768, 16'hFFFF);
		send_word(16'sh7FFF, 16'sh7FFF);
		send_word(16'sh8000, 16'sh7FFF);
		send_word(16'sd1234, -16'sd4321);
		send_word(16'sh8000, 16'sh8000);
		drain();

		// random settings, each phase a burst of random words
		for (int ph = 0; ph < 12; ph++) begin
			steady = ($urandom_range(0, 3) == 0);
			en = ($urandom_range(0, 5) != 0);
			case ($urandom_range(0, 3))
				0: base = 7'd0;
				1: base = 7'd1;
				2: base = 7'd127;
				default: base = 7'($urandom_range(1, 127));
			endcase
			case ($urandom_range(0, 4))
				0: sw = 16'd0;
				1: sw = 16'd32768;
				2: sw = 16'hFFFF;
				3: sw = 16'($urandom);
				default: sw = 16'($urandom_range(0, 32768));
			endcase
			case ($urandom_range(0, 3))
				0: dg = 16'd0;
				1: dg = 16'd32768;
				2: dg = 16'hFFFF;
				default: dg = 16'($urandom_range(0, 32768));
			endcase
			case ($urandom_range(0, 4))
				0: sc = 16'd0;
				1: sc = 16'd32768;
				2: sc = 16'hFFFF;
				default: sc = 16'($urandom_range(8192, 32768));
			endcase
			case ($urandom_range(0, 3))
				0: st = 16'd0;
				1: st = 16'hFFFF;
				2: st = 16'($urandom);
				default: st = 16'($urandom_range(1, 512));
			endcase
			if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_HI, 16'($urandom));
			program_regs(en, base, sw, dg, sc, st);
			repeat (90) send_word(rand_sample(), rand_sample());
			drain();
		end

		// let any stray word show up before the verdict
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_words == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
